// ===== hdl/fsla_pkg.sv =====
`timescale 1ns / 1ps
// Package of the fixed-slot free-list allocator.
// Holds the operation codes, result status codes, state encoding and field widths.
// It depends on nothing else.
package fsla_pkg;

  localparam int FUNC_W     = 1;
  localparam int REQ_W      = 16;
  localparam int IDX_IN_W   = 9;
  localparam int STATUS_W   = 3;
  localparam int GRANT_W    = 8;
  localparam int OFFSET_W   = 20;
  localparam int ITEM_W     = 13;
  localparam int SIZE_W     = ITEM_W + 1;
  localparam int ITEM_RESET = 16;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_BAD_FREE  = 3'd3,
    ST_NULL_FREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_INIT = 2'd0,
    S_IDLE = 2'd1,
    S_POP  = 2'd2
  } state_t;

endpackage

// ===== hdl/fsla_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the allocator: valid, ready and the request fields.
// It depends on fsla_pkg for the field widths.
interface fsla_req_if;
  logic                          valid;
  logic                          ready;
  logic [fsla_pkg::FUNC_W-1:0]   func;
  logic [fsla_pkg::REQ_W-1:0]    request_bytes;
  logic [fsla_pkg::IDX_IN_W-1:0] slot_index;
  logic                          free_is_null;

  modport source (output valid, func, request_bytes, slot_index, free_is_null, input ready);
  modport sink   (input valid, func, request_bytes, slot_index, free_is_null, output ready);
endinterface

// ===== hdl/fsla_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the allocator: valid, ready and the result fields.
// It depends on fsla_pkg for the field widths.
interface fsla_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fsla_pkg::STATUS_W-1:0] status;
  logic [fsla_pkg::GRANT_W-1:0]  granted_slot;
  logic [fsla_pkg::OFFSET_W-1:0] byte_offset;

  modport source (output valid, status, granted_slot, byte_offset, input ready);
  modport sink   (input valid, status, granted_slot, byte_offset, output ready);
endinterface

// ===== hdl/fsla_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel of the allocator: valid, ready and the item size.
// It depends on fsla_pkg for the data width.
interface fsla_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fsla_pkg::ITEM_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/fixed_slot_free_list_allocator.sv =====
`timescale 1ns / 1ps
// Fixed-slot free-list allocator: hands out and takes back NUM_SLOTS equal slots whose
// size is the configured item size rounded up to 16 bytes. The free list lives in a
// link memory with a registered read port. After reset the block writes the initial
// chain into that memory and takes no request; configuration writes are taken at any time.
// A free or a failing allocate goes straight to the result register; a successful
// allocate first passes S_POP, where the link memory read yields the new head.
// It depends on fsla_pkg, the three channel interfaces, fsla_ctrl and fsla_link_mem.
module fixed_slot_free_list_allocator #(
  parameter int NUM_SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  fsla_req_if.sink   in_req,
  fsla_rsp_if.source out_rsp,
  fsla_cfg_if.sink   cfg_wr
);
  import fsla_pkg::*;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LINK_W = $clog2(NUM_SLOTS + 1);

  logic [ITEM_W-1:0] item_bytes_r;
  logic [ITEM_W-1:0] item_bytes_nxt;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [LINK_W-1:0] mem_rdata;

  assign cfg_wr.ready   = 1'b1;
  assign item_bytes_nxt = (cfg_wr.valid && cfg_wr.ready) ? cfg_wr.data : item_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_bytes_r <= ITEM_W'(ITEM_RESET);
    end else begin
      item_bytes_r <= item_bytes_nxt;
    end
  end

  fsla_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W),
    .LINK_W    (LINK_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_req.valid),
    .in_ready         (in_req.ready),
    .in_func          (in_req.func),
    .in_request_bytes (in_req.request_bytes),
    .in_slot_index    (in_req.slot_index),
    .in_free_is_null  (in_req.free_is_null),
    .out_valid        (out_rsp.valid),
    .out_ready        (out_rsp.ready),
    .out_status       (out_rsp.status),
    .out_granted_slot (out_rsp.granted_slot),
    .out_byte_offset  (out_rsp.byte_offset),
    .item_bytes       (item_bytes_r),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  fsla_link_mem #(
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (IDX_W),
    .DATA_W (LINK_W)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== hdl/fsla_link_mem.sv =====
`timescale 1ns / 1ps
// Next-link memory of the free list: one write port and one registered read port.
// It depends on nothing else.
module fsla_link_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fsla_ctrl.sv =====
`timescale 1ns / 1ps
// Control of the allocator: link memory initialization, head pointer, pop and push
// sequencing and the result register. It depends on fsla_pkg.
module fsla_ctrl #(
  parameter int NUM_SLOTS = 256,
  parameter int IDX_W     = 8,
  parameter int LINK_W    = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fsla_pkg::FUNC_W-1:0]   in_func,
  input  logic [fsla_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [fsla_pkg::IDX_IN_W-1:0] in_slot_index,
  input  logic                          in_free_is_null,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fsla_pkg::STATUS_W-1:0] out_status,
  output logic [fsla_pkg::GRANT_W-1:0]  out_granted_slot,
  output logic [fsla_pkg::OFFSET_W-1:0] out_byte_offset,
  input  logic [fsla_pkg::ITEM_W-1:0]   item_bytes,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [LINK_W-1:0]             mem_wdata,
  output logic [IDX_W-1:0]              mem_raddr,
  input  logic [LINK_W-1:0]             mem_rdata
);
  import fsla_pkg::*;

  localparam int WIDE_W = LINK_W + IDX_IN_W;
  localparam int PROD_W = LINK_W + SIZE_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);

  state_t              state_r, state_nxt;
  logic [LINK_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [GRANT_W-1:0]  slot_r, slot_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;

  logic [SIZE_W-1:0]   slot_size;
  logic [PROD_W-1:0]   product;
  logic [WIDE_W-1:0]   idx_wide;
  logic                too_large;
  logic                list_empty;
  logic                bad_index;
  logic                accept;

  always_comb begin
    slot_size  = ({1'b0, item_bytes} + SIZE_W'(15)) & ~SIZE_W'(15);
    too_large  = in_request_bytes > REQ_W'(slot_size);
    list_empty = head_r >= NULL_LINK;
    idx_wide   = WIDE_W'(in_slot_index);
    bad_index  = idx_wide >= WIDE_W'(NUM_SLOTS);
    product    = PROD_W'(head_r) * PROD_W'(slot_size);
    in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    accept     = in_valid && in_ready;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    offset_nxt    = offset_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_wide[IDX_W-1:0];
    mem_wdata     = head_r;
    mem_raddr     = head_r[IDX_W-1:0];
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = LINK_W'(cnt_r) + LINK_W'(1);
        cnt_nxt   = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          slot_nxt   = '0;
          offset_nxt = '0;
          if (in_func == FUNC_ALLOC) begin
            if (too_large) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_TOO_LARGE;
            end else if (list_empty) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_EXHAUSTED;
            end else begin
              state_nxt = S_POP;
            end
          end else begin
            out_valid_nxt = 1'b1;
            if (in_free_is_null) begin
              status_nxt = ST_NULL_FREE;
            end else if (bad_index) begin
              status_nxt = ST_BAD_FREE;
            end else begin
              status_nxt = ST_OK;
              mem_we     = 1'b1;
              head_nxt   = LINK_W'(idx_wide);
            end
          end
        end
      end
      S_POP: begin
        head_nxt      = (mem_rdata > NULL_LINK) ? NULL_LINK : mem_rdata;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        slot_nxt      = GRANT_W'(head_r);
        offset_nxt    = OFFSET_W'(product);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    offset_r <= offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_granted_slot = slot_r;
  assign out_byte_offset  = offset_r;

endmodule

// ===== hdl/fsla_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the allocator and the bind that attaches them to the top level.
// It depends on fsla_pkg and on fixed_slot_free_list_allocator.
module fsla_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fsla_pkg::STATUS_W-1:0] out_status,
  input logic [fsla_pkg::GRANT_W-1:0]  out_granted_slot,
  input logic [fsla_pkg::OFFSET_W-1:0] out_byte_offset
);
  import fsla_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_granted_slot) && $stable(out_byte_offset))
    else $error("Result changed while it was stalled.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_granted_slot == '0) && (out_byte_offset == '0))
    else $error("A failed request carries a slot or an offset.");

  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("A request was offered ready right after reset.");

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid || !in_ready)
    else $error("An accepted request neither answered nor held off the next one.");

endmodule

bind fixed_slot_free_list_allocator fsla_checker u_fsla_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_status       (out_rsp.status),
  .out_granted_slot (out_rsp.granted_slot),
  .out_byte_offset  (out_rsp.byte_offset)
);
